// File: design/window_filter_3x3_blur_edge_assert.svh
// Assertion macros for the 3x3 window filter.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef WINDOW_FILTER_3X3_BLUR_EDGE_ASSERT_SVH
`define WINDOW_FILTER_3X3_BLUR_EDGE_ASSERT_SVH
// Same-cycle implication.
`define WF3_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication.
`define WF3_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// File: design/wf3_pkg.sv
// Shared types and constants of the 3x3 window filter.
// No dependencies.
package wf3_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SQRT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic calc;
    logic sqrt_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic edge_mode;
    logic sqrt_last;
    logic out_free;
  } sts_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int PIX_W    = 24;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

  // floor(x/10) == (x*3277) >> 15 for every 9-pixel sum.
  localparam logic [11:0] RECIP_TEN   = 12'd3277;
  localparam int          RECIP_SHIFT = 15;
  localparam logic [7:0]  SAT_VAL     = 8'd255;

endpackage

// File: design/wf3_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/wf3_ctrl.sv
// Controller state machine of the 3x3 window filter.
// Depends on wf3_pkg.
module wf3_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wf3_pkg::sts_t sts,
  output wf3_pkg::cmd_t cmd
);

  wf3_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wf3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      wf3_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = wf3_pkg::ST_READ;
      end
      wf3_pkg::ST_READ: begin
        cmd.step  = 1'b1;
        state_nxt = sts.emit ? wf3_pkg::ST_CALC : wf3_pkg::ST_IDLE;
      end
      wf3_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.edge_mode ? wf3_pkg::ST_SQRT : wf3_pkg::ST_LOAD;
      end
      wf3_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_nxt = wf3_pkg::ST_LOAD;
      end
      wf3_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = wf3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wf3_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/wf3_dp.sv
// Datapath of the 3x3 window filter: configuration, line stores, window,
// position counters, blur divider, bit-serial square root, output register.
// Depends on wf3_pkg and wf3_ram.
module wf3_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wf3_pkg::cmd_t                    cmd,
  output wf3_pkg::sts_t                    sts,
  input  logic                             cfg_we,
  input  logic [wf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wf3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  input  logic                             in_flush,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_frame_end
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int FW  = $clog2(MAX_WIDTH + 2);
  localparam int CW  = (FW > wf3_pkg::WIDTH_W) ? FW : wf3_pkg::WIDTH_W;
  localparam int HW  = wf3_pkg::HEIGHT_W;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

  logic                          mode_r;
  logic [wf3_pkg::WIDTH_W-1:0]   img_w_r;
  logic [HW-1:0]                 img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      img_w_r <= wf3_pkg::RST_WIDTH;
      img_h_r <= wf3_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        wf3_pkg::CFG_MODE:   mode_r  <= cfg_wdata[0];
        wf3_pkg::CFG_WIDTH:  img_w_r <= cfg_wdata[wf3_pkg::WIDTH_W-1:0];
        wf3_pkg::CFG_HEIGHT: img_h_r <= cfg_wdata[HW-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] iw, w;
  logic [HW-1:0] h;

  always_comb begin
    iw = CW'(img_w_r);
    if (iw == '0)        w = CW'(1);
    else if (iw > MAXW)  w = MAXW;
    else                 w = iw;
    if (img_h_r == '0)                      h = HW'(1);
    else if (img_h_r > wf3_pkg::MAX_HEIGHT) h = wf3_pkg::MAX_HEIGHT;
    else                                    h = img_h_r;
  end

  logic [AW-1:0]               col_pos_r, col_eff, col_r, col_nxt;
  logic [CW-1:0]               fill_r, out_col, col_inc;
  logic [wf3_pkg::ROW_W-1:0]   row_r;
  logic [wf3_pkg::PIX_W-1:0]   pix_r, up_q, mid_q;
  logic [wf3_pkg::PIX_W-1:0]   win_r [6];
  logic                        emit, at_left, at_right, at_top, at_bot;

  assign col_eff = (CW'(col_pos_r) >= w) ? '0 : col_pos_r;

  wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .wr_en(cmd.step), .wr_addr(col_r), .wr_data(mid_q),
    .rd_en(cmd.accept), .rd_addr(col_eff), .rd_data(up_q)
  );

  wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .wr_en(cmd.step), .wr_addr(col_r), .wr_data(pix_r),
    .rd_en(cmd.accept), .rd_addr(col_eff), .rd_data(mid_q)
  );

  always_comb begin
    col_inc  = CW'(col_r) + CW'(1);
    col_nxt  = (col_inc >= w) ? '0 : col_inc[AW-1:0];
    emit     = (fill_r >= w + CW'(1));
    out_col  = (col_r == '0) ? (w - CW'(1)) : (CW'(col_r) - CW'(1));
    at_left  = (out_col == '0);
    at_right = (out_col + CW'(1) >= w);
    at_top   = (row_r == '0);
    at_bot   = ({1'b0, row_r} + HW'(1) >= h);
  end

  // Neighborhood per channel, masked at the image border.
  logic [7:0]  nb  [3][9];
  logic [11:0] sum_c [3];
  logic [7:0]  adx [3], ady [3];
  logic [16:0] sq_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        nb[c][k*3]   = win_r[k][c*8 +: 8];
        nb[c][k*3+1] = win_r[3+k][c*8 +: 8];
      end
      nb[c][2] = up_q[c*8 +: 8];
      nb[c][5] = mid_q[c*8 +: 8];
      nb[c][8] = pix_r[c*8 +: 8];
      if (at_left)  begin nb[c][0] = '0; nb[c][3] = '0; nb[c][6] = '0; end
      if (at_right) begin nb[c][2] = '0; nb[c][5] = '0; nb[c][8] = '0; end
      if (at_top)   begin nb[c][0] = '0; nb[c][1] = '0; nb[c][2] = '0; end
      if (at_bot)   begin nb[c][6] = '0; nb[c][7] = '0; nb[c][8] = '0; end
      sum_c[c] = '0;
      for (int k = 0; k < 9; k++) begin
        sum_c[c] = sum_c[c] + 12'(nb[c][k]);
      end
      adx[c] = (nb[c][3] >= nb[c][4]) ? (nb[c][3] - nb[c][4]) : (nb[c][4] - nb[c][3]);
      ady[c] = (nb[c][1] >= nb[c][4]) ? (nb[c][1] - nb[c][4]) : (nb[c][4] - nb[c][1]);
      sq_c[c] = 17'(16'(adx[c]) * 16'(adx[c])) + 17'(16'(ady[c]) * 16'(ady[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_r     <= '0;
      fill_r    <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (cmd.step) begin
      for (int k = 0; k < 3; k++) win_r[k] <= win_r[3+k];
      win_r[3]  <= up_q;
      win_r[4]  <= mid_q;
      win_r[5]  <= pix_r;
      col_pos_r <= col_nxt;
      if (!emit) begin
        fill_r <= fill_r + CW'(1);
      end else if (at_bot && at_right) begin
        fill_r    <= '0;
        col_pos_r <= '0;
        row_r     <= '0;
      end else if (at_right) begin
        row_r <= row_r + wf3_pkg::ROW_W'(1);
      end
    end
  end

  logic        md_r, fe_r, sat_r [3];
  logic [11:0] sum_r [3];
  logic [16:0] sq_r  [3];
  logic [7:0]  root_r [3];
  logic [2:0]  bit_r;
  logic [23:0] quo [3];
  logic [7:0]  trial [3];
  logic [15:0] tsq [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo[c]   = 24'(sum_r[c]) * 24'(wf3_pkg::RECIP_TEN);
      trial[c] = root_r[c] | (8'd1 << bit_r);
      tsq[c]   = 16'(trial[c]) * 16'(trial[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r <= col_eff;
      pix_r <= in_flush ? '0 : {in_blue, in_green, in_red};
    end
    if (cmd.step) begin
      md_r <= mode_r;
      fe_r <= at_bot && at_right;
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= sum_c[c];
        sq_r[c]  <= sq_c[c];
      end
    end
    if (cmd.calc) begin
      bit_r <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        root_r[c] <= md_r ? 8'd0 : quo[c][wf3_pkg::RECIP_SHIFT +: 8];
        sat_r[c]  <= md_r && sq_r[c][16];
      end
    end
    if (cmd.sqrt_step) begin
      bit_r <= bit_r - 3'd1;
      for (int c = 0; c < 3; c++) begin
        if (tsq[c] <= sq_r[c][15:0]) root_r[c] <= trial[c];
      end
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_red       <= sat_r[0] ? wf3_pkg::SAT_VAL : root_r[0];
      out_green     <= sat_r[1] ? wf3_pkg::SAT_VAL : root_r[1];
      out_blue      <= sat_r[2] ? wf3_pkg::SAT_VAL : root_r[2];
      out_frame_end <= fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.emit      = emit;
  assign sts.edge_mode = md_r;
  assign sts.sqrt_last = (bit_r == 3'd0);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// File: design/window_filter_3x3_blur_edge.sv
// 3x3 window filter on an RGB pixel stream (box blur or gradient magnitude).
// Pixels enter in raster order on the in_ channel (valid/ready); filtered
// pixels leave on the out_ channel (valid/ready). Registers are written on
// the cfg_ port: index 0 mode, 1 image width, 2 image height.
// Each item is taken alone. A pixel that only fills the window passes
// through the idle and read states; a blur result goes on through calc and
// load; an edge result adds the 8-step bit-serial square root. The next item
// is taken in the cycle after the result is loaded into the output register.
// Result for pixel k leaves with item k+width+1, so width+1 flush items
// drain a frame; frame_end marks its last pixel.
// Reset clears the FSM, counters, window and output valid and loads mode 0,
// width 640, height 480. The line stores are not cleared; border masking
// hides stale entries.
// A stalled receiver holds the output register. Items that yield no result
// are still taken; the next result waits in the datapath until the output
// frees, and the input stalls meanwhile.
// Depends on wf3_pkg, wf3_ctrl, wf3_dp and the assertion header.
`include "window_filter_3x3_blur_edge_assert.svh"
module window_filter_3x3_blur_edge #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wf3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic                           in_flush,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_frame_end
);

  wf3_pkg::cmd_t cmd;
  wf3_pkg::sts_t sts;

  wf3_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  wf3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_flush(in_flush),
    .out_ready(out_ready), .out_valid(out_valid),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_frame_end(out_frame_end)
  );

  `WF3_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  `WF3_ASSERT_NXT(a_read_next, in_valid && in_ready, cmd.step, "line store read not used")
  `WF3_ASSERT_IMP(a_load_free, cmd.load, sts.out_free, "output register overwritten")

endmodule
